>>> sv/rptb_pkg.sv
// rptb_pkg: shared constants, codes and types of the three-level radix page table builder
// used by every module of the block; depends on nothing
package rptb_pkg;

  localparam int PAGE_BYTES       = 4096;
  localparam int ENTRIES_PER_PAGE = 512;
  localparam int ENTRY_BYTES      = 8;

  localparam int PAGE_SHIFT  = $clog2(PAGE_BYTES);
  localparam int EPP_SHIFT   = $clog2(ENTRIES_PER_PAGE);
  localparam int ENTRY_SHIFT = $clog2(ENTRY_BYTES);

  // field widths
  localparam int IMG_BYTES_W = 40;
  localparam int ADDR_W      = 64;
  localparam int L1_W        = 10;
  localparam int L2_W        = 19;
  localparam int PG_W        = 28;
  localparam int TB_W        = 31;
  localparam int ST_W        = 3;

  // widths of the unclipped page counts inside the plan pipeline
  localparam int IMGC_W = IMG_BYTES_W + 1 - PAGE_SHIFT;
  localparam int L2C_W  = IMGC_W + 1 - EPP_SHIFT;
  localparam int L1C_W  = L2C_W + 1 - EPP_SHIFT;

  localparam logic [PG_W-1:0] IDX_MAX = {PG_W{1'b1}};

  // status codes
  localparam logic [ST_W-1:0] ST_ENTRY    = 3'd0;
  localparam logic [ST_W-1:0] ST_ROOT     = 3'd1;
  localparam logic [ST_W-1:0] ST_MISALIGN = 3'd2;
  localparam logic [ST_W-1:0] ST_NO_PLAN  = 3'd3;
  localparam logic [ST_W-1:0] ST_PAST_END = 3'd4;

  // which table holds the parent entry
  localparam logic [1:0] RG_ROOT_TBL = 2'd0;
  localparam logic [1:0] RG_L1_TBL   = 2'd1;
  localparam logic [1:0] RG_L2_TBL   = 2'd2;

  // plan pipeline depth, counted from the config transfer
  localparam int PLAN_LAT = 4;
  localparam int SETTLE_W = $clog2(PLAN_LAT + 1);

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [ADDR_W-1:0] page_address;
    logic              first;
  } in_t;

  typedef struct packed {
    logic              plan_ok;
    logic [L1_W-1:0]   level1_pages;
    logic [L2_W-1:0]   level2_pages;
    logic [PG_W-1:0]   image_pages;
    logic [TB_W-1:0]   table_bytes;
    logic [PG_W-1:0]   allocation_pages;
    logic [ST_W-1:0]   status;
    logic [TB_W-1:0]   entry_offset;
    logic [ADDR_W-1:0] entry_value;
    logic              last;
    logic              error_seen;
  } out_t;

  typedef struct packed {
    logic            ok;
    logic [L1_W-1:0] l1;
    logic [L2_W-1:0] l2;
    logic [PG_W-1:0] img;
    logic [TB_W-1:0] tbytes;
    logic [PG_W-1:0] alloc;
    logic [PG_W-1:0] bnd2;   // first page index of the image region
    logic [TB_W-1:0] bias1;  // offset bias for entries in the first-level tables
    logic [TB_W-1:0] bias2;  // offset bias for entries in the second-level tables
  } plan_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [PG_W-1:0]   idx;
    logic [ST_W-1:0]   status;
    logic [1:0]        region;
    logic              last;
    logic              err;
  } job_t;

endpackage

>>> sv/radix3_page_table_builder.sv
// radix3_page_table_builder: top level joining plan, front, queue and back
// depends on rptb_pkg, rptb_plan, rptb_front, rptb_queue, rptb_back
//
// Write the image size on the cfg channel while no page is in flight; the layout plan
// then settles in a pipelined chain of ceiling divisions, and in_ready stays low until
// it has settled, after each config write and after reset. After that the block takes one
// page address per cycle while the queue has room and returns one result per page. A
// two-entry queue sits between the classifying front and the result register, so a
// stalled result side does not stop input until the queue is full. Raise first with
// the root page to restart numbering and clear the sticky error flag.
module radix3_page_table_builder (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [rptb_pkg::IMG_BYTES_W-1:0] cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  rptb_pkg::in_t                    in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output rptb_pkg::out_t                   out_data
);

  rptb_pkg::plan_t plan;
  logic            plan_ready;
  logic            q_ready, push, pop, pop_valid;
  rptb_pkg::job_t  push_job, pop_job;

  rptb_plan u_plan (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .plan       (plan),
    .plan_ready (plan_ready)
  );

  rptb_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .plan       (plan),
    .plan_ready (plan_ready),
    .q_ready    (q_ready),
    .push       (push),
    .push_job   (push_job)
  );

  rptb_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (push_job),
    .push_ready (q_ready),
    .pop        (pop),
    .pop_valid  (pop_valid),
    .pop_job    (pop_job)
  );

  rptb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_job   (pop_job),
    .pop       (pop),
    .plan      (plan),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> sv/rptb_plan.sv
// rptb_plan: image size register and the pipelined layout plan derived from it
// depends on rptb_pkg
module rptb_plan (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rptb_pkg::IMG_BYTES_W-1:0] cfg_data,
  output rptb_pkg::plan_t                 plan,
  output logic                            plan_ready
);

  localparam int SA_W = rptb_pkg::IMG_BYTES_W + 1;
  localparam int SB_W = rptb_pkg::IMGC_W + 1;
  localparam int SC_W = rptb_pkg::L2C_W + 1;
  localparam int TB_W = rptb_pkg::TB_W;
  localparam int PG_W = rptb_pkg::PG_W;

  logic [rptb_pkg::IMG_BYTES_W-1:0] image_bytes_r;
  logic [rptb_pkg::SETTLE_W-1:0]    settle_r, settle_nxt;

  logic [rptb_pkg::IMGC_W-1:0] img_a_r, img_b_r, img_c_r;
  logic                        zero_a_r, zero_b_r;
  logic [rptb_pkg::L2C_W-1:0]  l2_b_r, l2_c_r;
  logic [rptb_pkg::L1C_W-1:0]  l1_c_r;
  logic                        ok_c_r;
  rptb_pkg::plan_t             plan_r, plan_nxt;

  logic [SA_W-1:0] sum_a;
  logic [SB_W-1:0] sum_b;
  logic [SC_W-1:0] sum_c;
  logic [rptb_pkg::L1C_W-1:0] l1_c_nxt;
  logic [TB_W-1:0] l1w, l2w, tpages;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_bytes_r <= '0;
      settle_r      <= rptb_pkg::SETTLE_W'(rptb_pkg::PLAN_LAT);
    end else begin
      if (cfg_valid) begin
        image_bytes_r <= cfg_data;
      end
      settle_r <= settle_nxt;
    end
  end

  always_comb begin
    settle_nxt = settle_r;
    if (cfg_valid) begin
      settle_nxt = rptb_pkg::SETTLE_W'(rptb_pkg::PLAN_LAT);
    end else if (settle_r != '0) begin
      settle_nxt = settle_r - 1'b1;
    end
  end

  assign plan_ready = (settle_r == '0);

  // ceiling divisions by powers of two, one per stage
  assign sum_a    = {1'b0, image_bytes_r} + SA_W'(rptb_pkg::PAGE_BYTES - 1);
  assign sum_b    = {1'b0, img_a_r} + SB_W'(rptb_pkg::ENTRIES_PER_PAGE - 1);
  assign sum_c    = {1'b0, l2_b_r} + SC_W'(rptb_pkg::ENTRIES_PER_PAGE - 1);
  assign l1_c_nxt = sum_c[SC_W-1:rptb_pkg::EPP_SHIFT];

  always_ff @(posedge clk) begin
    img_a_r  <= sum_a[SA_W-1:rptb_pkg::PAGE_SHIFT];
    zero_a_r <= (image_bytes_r == '0);
    img_b_r  <= img_a_r;
    zero_b_r <= zero_a_r;
    l2_b_r   <= sum_b[SB_W-1:rptb_pkg::EPP_SHIFT];
    img_c_r  <= img_b_r;
    l2_c_r   <= l2_b_r;
    l1_c_r   <= l1_c_nxt;
    // a single root page holds entries for at most one page's worth of first-level pages
    ok_c_r   <= !zero_b_r && (l1_c_nxt <= rptb_pkg::L1C_W'(rptb_pkg::ENTRIES_PER_PAGE));
    plan_r   <= plan_nxt;
  end

  assign l1w    = TB_W'(l1_c_r);
  assign l2w    = TB_W'(l2_c_r);
  assign tpages = TB_W'(1) + l1w + l2w;

  // offset = idx * entry size + bias of the region, all modulo the offset width
  always_comb begin
    plan_nxt = '0;
    if (ok_c_r) begin
      plan_nxt.ok     = 1'b1;
      plan_nxt.l1     = rptb_pkg::L1_W'(l1_c_r);
      plan_nxt.l2     = rptb_pkg::L2_W'(l2_c_r);
      plan_nxt.img    = PG_W'(img_c_r);
      plan_nxt.tbytes = tpages << rptb_pkg::PAGE_SHIFT;
      plan_nxt.bnd2   = PG_W'(1) + PG_W'(l1_c_r) + PG_W'(l2_c_r);
      plan_nxt.alloc  = PG_W'(1) + PG_W'(l1_c_r) + PG_W'(l2_c_r) + PG_W'(img_c_r);
      plan_nxt.bias1  = TB_W'(rptb_pkg::PAGE_BYTES - rptb_pkg::ENTRY_BYTES)
                        - (l1w << rptb_pkg::ENTRY_SHIFT);
      plan_nxt.bias2  = ((TB_W'(1) + l1w) << rptb_pkg::PAGE_SHIFT)
                        - TB_W'(rptb_pkg::ENTRY_BYTES)
                        - ((l1w + l2w) << rptb_pkg::ENTRY_SHIFT);
    end
  end

  assign plan = plan_r;

endmodule

>>> sv/rptb_front.sv
// rptb_front: accepts page addresses, numbers them and classifies each page
// depends on rptb_pkg
module rptb_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  rptb_pkg::in_t    in_data,
  input  rptb_pkg::plan_t  plan,
  input  logic             plan_ready,
  input  logic             q_ready,
  output logic             push,
  output rptb_pkg::job_t   push_job
);

  localparam int PG_W = rptb_pkg::PG_W;

  logic [PG_W-1:0] page_index_r, page_index_nxt;
  logic            err_r, err_nxt;
  logic [PG_W-1:0] idx;
  logic            misaligned;
  logic [rptb_pkg::ST_W-1:0] status;
  logic [1:0]      region;

  assign in_ready = plan_ready && q_ready;
  assign push     = in_valid && in_ready;

  assign idx        = in_data.first ? '0 : page_index_r;
  assign misaligned = (in_data.page_address[rptb_pkg::PAGE_SHIFT-1:0] != '0);

  always_comb begin
    priority if (!plan.ok) begin
      status = rptb_pkg::ST_NO_PLAN;
    end else if (idx >= plan.alloc) begin
      status = rptb_pkg::ST_PAST_END;
    end else if (misaligned) begin
      status = rptb_pkg::ST_MISALIGN;
    end else if (idx == '0) begin
      status = rptb_pkg::ST_ROOT;
    end else begin
      status = rptb_pkg::ST_ENTRY;
    end
  end

  always_comb begin
    priority if (idx <= PG_W'(plan.l1)) begin
      region = rptb_pkg::RG_ROOT_TBL;
    end else if (idx < plan.bnd2) begin
      region = rptb_pkg::RG_L1_TBL;
    end else begin
      region = rptb_pkg::RG_L2_TBL;
    end
  end

  assign err_nxt = (in_data.first ? 1'b0 : err_r)
                   || (status == rptb_pkg::ST_MISALIGN)
                   || (status == rptb_pkg::ST_NO_PLAN)
                   || (status == rptb_pkg::ST_PAST_END);

  assign page_index_nxt = (idx < rptb_pkg::IDX_MAX) ? idx + 1'b1 : idx;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_index_r <= '0;
      err_r        <= 1'b0;
    end else if (push) begin
      page_index_r <= page_index_nxt;
      err_r        <= err_nxt;
    end
  end

  always_comb begin
    push_job        = '0;
    push_job.addr   = in_data.page_address;
    push_job.idx    = idx;
    push_job.status = status;
    push_job.region = region;
    push_job.last   = plan.ok && ({1'b0, idx} + 1'b1 == {1'b0, plan.alloc});
    push_job.err    = err_nxt;
  end

endmodule

>>> sv/rptb_queue.sv
// rptb_queue: short job queue between the classifying front and the result back
// depends on rptb_pkg
module rptb_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  rptb_pkg::job_t push_job,
  output logic           push_ready,
  input  logic           pop,
  output logic           pop_valid,
  output rptb_pkg::job_t pop_job
);

  rptb_pkg::job_t                mem_r [rptb_pkg::QDEPTH];
  logic [rptb_pkg::QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [rptb_pkg::QCNT_W-1:0]   count_r;

  assign push_ready = (count_r != rptb_pkg::QCNT_W'(rptb_pkg::QDEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_job    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == rptb_pkg::QPTR_W'(rptb_pkg::QDEPTH - 1)) ? '0
                    : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == rptb_pkg::QPTR_W'(rptb_pkg::QDEPTH - 1)) ? '0
                    : rd_ptr_r + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

>>> sv/rptb_back.sv
// rptb_back: forms the parent entry offset and value and holds the result register
// depends on rptb_pkg
module rptb_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            pop_valid,
  input  rptb_pkg::job_t  pop_job,
  output logic            pop,
  input  rptb_pkg::plan_t plan,
  output logic            out_valid,
  input  logic            out_ready,
  output rptb_pkg::out_t  out_data
);

  localparam int TB_W = rptb_pkg::TB_W;

  logic           out_valid_r;
  rptb_pkg::out_t out_data_r, out_data_nxt;
  logic [TB_W-1:0] bias, scaled;

  assign pop = pop_valid && (!out_valid_r || out_ready);

  always_comb begin
    unique case (pop_job.region)
      rptb_pkg::RG_L1_TBL: bias = plan.bias1;
      rptb_pkg::RG_L2_TBL: bias = plan.bias2;
      default:             bias = TB_W'(0) - TB_W'(rptb_pkg::ENTRY_BYTES);
    endcase
  end

  assign scaled = TB_W'(pop_job.idx) << rptb_pkg::ENTRY_SHIFT;

  always_comb begin
    out_data_nxt                  = '0;
    out_data_nxt.plan_ok          = plan.ok;
    out_data_nxt.level1_pages     = plan.l1;
    out_data_nxt.level2_pages     = plan.l2;
    out_data_nxt.image_pages      = plan.img;
    out_data_nxt.table_bytes      = plan.tbytes;
    out_data_nxt.allocation_pages = plan.alloc;
    out_data_nxt.status           = pop_job.status;
    out_data_nxt.last             = pop_job.last;
    out_data_nxt.error_seen       = pop_job.err;
    if (pop_job.status == rptb_pkg::ST_ENTRY) begin
      out_data_nxt.entry_offset = scaled + bias;
      out_data_nxt.entry_value  = pop_job.addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> sv/rptb_checker.sv
// rptb_checker: port-level checks of the page table builder, bound to the top level
// depends on rptb_pkg and radix3_page_table_builder
module rptb_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           out_valid,
  input logic           out_ready,
  input rptb_pkg::out_t out_data
);

  // a stalled result transfer holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // without a valid plan every page is rejected and no layout is shown
  a_no_plan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.plan_ok |->
      out_data.status == rptb_pkg::ST_NO_PLAN && out_data.allocation_pages == '0
      && !out_data.last)
    else $error("invalid plan result inconsistent");

  // only written entries carry an offset and value
  a_entry_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != rptb_pkg::ST_ENTRY |->
      out_data.entry_offset == '0 && out_data.entry_value == '0)
    else $error("entry fields set on a non-entry status");

  // an error status always shows in the sticky flag
  a_error_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == rptb_pkg::ST_MISALIGN
                  || out_data.status == rptb_pkg::ST_NO_PLAN
                  || out_data.status == rptb_pkg::ST_PAST_END) |-> out_data.error_seen)
    else $error("error status without sticky flag");

  // a page past the end can never be the last page
  a_past_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == rptb_pkg::ST_PAST_END |-> !out_data.last)
    else $error("past-end page flagged last");

endmodule

bind radix3_page_table_builder rptb_checker u_rptb_checker (.*);
